>>> src/aelb_pkg.sv
`default_nettype none
package aelb_pkg;

  typedef enum logic [2:0] {
    ACT_ADD   = 3'd0,
    ACT_READ  = 3'd1,
    ACT_CLEAR = 3'd2,
    ACT_PURGE = 3'd3,
    ACT_DAILY = 3'd4
  } action_e;

  localparam logic [31:0] RetentionReset = 32'd604800;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] event_time;
    logic [3:0]  event_kind;
    logic [31:0] relay_on_stamp;
    logic [31:0] relay_off_stamp;
    logic        limit_hit;
    logic [31:0] limit_stamp;
    logic [7:0]  read_index;
    logic [31:0] now_time;
    logic [4:0]  now_day;
  } in_item_t;

  typedef struct packed {
    logic        entry_valid;
    logic [31:0] out_time;
    logic [3:0]  out_kind;
    logic [31:0] out_relay_on;
    logic [31:0] out_relay_off;
    logic        out_limit_hit;
    logic [31:0] out_limit_time;
    logic [4:0]  entry_count;
  } out_item_t;

  // one stored record
  typedef struct packed {
    logic [31:0] stamp;
    logic [3:0]  kind;
    logic [31:0] relay_on;
    logic [31:0] relay_off;
    logic        limit_flag;
    logic [31:0] limit_time;
  } entry_t;

  // classified command from front to back
  typedef enum logic [2:0] {
    CMD_ADD,
    CMD_READ,
    CMD_CLEAR,
    CMD_PURGE,
    CMD_NOP
  } cmd_e;

  typedef struct packed {
    cmd_e        cmd;
    entry_t      rec;
    logic [7:0]  index;
    logic [31:0] now_time;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_PURGE,
    ST_DONE
  } back_state_e;

endpackage
`default_nettype wire

>>> src/aging_event_log_buffer_top.sv
`default_nettype none
// add, clear and a daily check without purge finish when accepted; a read passes
// through ST_READ; a purge steps through ST_PURGE (one stored entry examined per cycle), then ST_DONE
// the back end takes no new request while busy in a read or purge or while a result waits to be popped;
// the store has one write and one read port
// reset: log empty, day register zero, retention 604800 s; store contents undefined
module aging_event_log_buffer_top #(
  parameter int LOG_DEPTH = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push,
  output logic                     full,
  input  wire aelb_pkg::in_item_t  in_item_i,
  output logic                     empty,
  input  wire logic                pop,
  output aelb_pkg::out_item_t      out_item_o,
  input  wire logic                cfg_we_i,
  input  wire logic [31:0]         cfg_wdata_i
);
  logic           cmd_valid, cmd_ready;
  aelb_pkg::cmd_t cmd;
  logic [31:0]    retention_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) retention_q <= aelb_pkg::RetentionReset;
    else if (cfg_we_i) retention_q <= cfg_wdata_i;
  end

  aelb_front u_front (
    .clk_i, .rst_ni, .push, .full, .in_item_i,
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  aelb_back #(.LOG_DEPTH(LOG_DEPTH)) u_back (
    .clk_i, .rst_ni,
    .retention_i (retention_q),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .empty, .pop, .out_item_o
  );
endmodule
`default_nettype wire

>>> src/aelb_front.sv
`default_nettype none
// classifies requests, tracks the daily check day
module aelb_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push,
  output logic                   full,
  input  wire aelb_pkg::in_item_t in_item_i,
  output logic                   cmd_valid_o,
  input  wire logic              cmd_ready_i,
  output aelb_pkg::cmd_t         cmd_o
);
  logic               valid_q;
  aelb_pkg::cmd_t     cmd_q, cmd_d;
  logic [4:0]         day_q;
  logic               take;

  assign full        = valid_q && !cmd_ready_i;
  assign take        = push && !full;
  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

  always_comb begin
    cmd_d.rec.stamp      = in_item_i.event_time;
    cmd_d.rec.kind       = in_item_i.event_kind;
    cmd_d.rec.relay_on   = in_item_i.relay_on_stamp;
    cmd_d.rec.relay_off  = in_item_i.relay_off_stamp;
    cmd_d.rec.limit_flag = in_item_i.limit_hit;
    cmd_d.rec.limit_time = in_item_i.limit_stamp;
    cmd_d.index          = in_item_i.read_index;
    cmd_d.now_time       = in_item_i.now_time;
    case (in_item_i.action)
      aelb_pkg::ACT_ADD:   cmd_d.cmd = aelb_pkg::CMD_ADD;
      aelb_pkg::ACT_READ:  cmd_d.cmd = aelb_pkg::CMD_READ;
      aelb_pkg::ACT_CLEAR: cmd_d.cmd = aelb_pkg::CMD_CLEAR;
      aelb_pkg::ACT_PURGE: cmd_d.cmd = aelb_pkg::CMD_PURGE;
      aelb_pkg::ACT_DAILY: begin
        cmd_d.cmd = (day_q != in_item_i.now_day) ? aelb_pkg::CMD_PURGE : aelb_pkg::CMD_NOP;
      end
      default:             cmd_d.cmd = aelb_pkg::CMD_NOP;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      day_q   <= '0;
    end else begin
      if (take) begin
        valid_q <= 1'b1;
        if (in_item_i.action == aelb_pkg::ACT_DAILY) day_q <= in_item_i.now_day;
      end else if (cmd_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) cmd_q <= cmd_d;
  end
endmodule
`default_nettype wire

>>> src/aelb_back.sv
`default_nettype none
// circular store with head pointer; purge compacts over one entry per cycle
module aelb_back #(
  parameter int LOG_DEPTH = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [31:0]        retention_i,
  input  wire logic               cmd_valid_i,
  output logic                    cmd_ready_o,
  input  wire aelb_pkg::cmd_t     cmd_i,
  output logic                    empty,
  input  wire logic               pop,
  output aelb_pkg::out_item_t     out_item_o
);
  localparam int AW = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
  localparam int CW = $clog2(LOG_DEPTH + 1);
  localparam logic [CW-1:0] Depth = CW'(LOG_DEPTH);

  aelb_pkg::entry_t mem [LOG_DEPTH];

  aelb_pkg::back_state_e state_q, state_d;
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] scan_q, scan_d, keep_q, keep_d;
  logic [31:0]   now_q;
  logic          hit_q;
  logic          out_valid_q;
  aelb_pkg::out_item_t out_q;
  aelb_pkg::entry_t    rd_q;
  logic          accept;
  logic          wr_en;
  logic [AW-1:0] wr_addr, rd_addr;
  aelb_pkg::entry_t wr_data;
  logic          rd_en;
  logic          finish;
  logic          in_range;

  function automatic logic [AW-1:0] wrap(input logic [AW-1:0] base, input logic [CW-1:0] off);
    logic [AW+CW:0] s;
    s = (AW+CW+1)'(base) + (AW+CW+1)'(off);
    if (s >= (AW+CW+1)'(LOG_DEPTH)) s = s - (AW+CW+1)'(LOG_DEPTH);
    return s[AW-1:0];
  endfunction

  assign accept      = cmd_valid_i && cmd_ready_o;
  assign cmd_ready_o = (state_q == aelb_pkg::ST_IDLE) && !out_valid_q;
  assign empty       = !out_valid_q;
  assign out_item_o  = out_q;
  assign in_range    = (32'(cmd_i.index) < 32'(count_q));

  always_comb begin
    state_d = state_q;
    head_d  = head_q;
    count_d = count_q;
    scan_d  = scan_q;
    keep_d  = keep_q;
    wr_en   = 1'b0;
    wr_addr = wrap(head_q, count_q);
    wr_data = cmd_i.rec;
    rd_en   = 1'b0;
    rd_addr = wrap(head_q, scan_q);
    finish  = 1'b0;
    case (state_q)
      aelb_pkg::ST_IDLE: begin
        if (accept) begin
          case (cmd_i.cmd)
            aelb_pkg::CMD_ADD: begin
              wr_en = 1'b1;
              if (count_q == Depth) begin
                wr_addr = head_q;
                head_d  = wrap(head_q, CW'(1));
              end else begin
                count_d = count_q + CW'(1);
              end
              finish = 1'b1;
            end
            aelb_pkg::CMD_READ: begin
              rd_en   = 1'b1;
              rd_addr = wrap(head_q, CW'(cmd_i.index[AW-1:0]));
              state_d = aelb_pkg::ST_READ;
            end
            aelb_pkg::CMD_CLEAR: begin
              count_d = '0;
              finish  = 1'b1;
            end
            aelb_pkg::CMD_PURGE: begin
              scan_d  = '0;
              keep_d  = '0;
              state_d = aelb_pkg::ST_PURGE;
            end
            default: finish = 1'b1;
          endcase
        end
      end
      aelb_pkg::ST_READ: begin
        finish  = 1'b1;
        state_d = aelb_pkg::ST_IDLE;
      end
      aelb_pkg::ST_PURGE: begin
        // read entry scan this cycle
        if (scan_q == count_q) begin
          count_d = keep_q;
          state_d = aelb_pkg::ST_DONE;
        end else begin
          rd_en   = 1'b1;
          scan_d  = scan_q + CW'(1);
          state_d = aelb_pkg::ST_PURGE;
        end
        // write back the entry read last cycle if it survives
        if (scan_q != '0 && (now_q - rd_q.stamp) < retention_i) begin
          wr_en   = 1'b1;
          wr_addr = wrap(head_q, keep_q);
          wr_data = rd_q;
          keep_d  = keep_q + CW'(1);
          if (scan_q == count_q) count_d = keep_q + CW'(1);
        end
      end
      aelb_pkg::ST_DONE: begin
        finish  = 1'b1;
        state_d = aelb_pkg::ST_IDLE;
      end
      default: state_d = aelb_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= aelb_pkg::ST_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      scan_q      <= '0;
      keep_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
      scan_q  <= scan_d;
      keep_q  <= keep_d;
      if (finish) out_valid_q <= 1'b1;
      else if (pop) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_q <= mem[rd_addr];
    if (accept) begin
      now_q <= cmd_i.now_time;
      hit_q <= in_range;
    end
    if (finish) begin
      out_q.entry_count <= 5'(count_d);
      if (state_q == aelb_pkg::ST_READ && hit_q) begin
        out_q.entry_valid    <= 1'b1;
        out_q.out_time       <= rd_q.stamp;
        out_q.out_kind       <= rd_q.kind;
        out_q.out_relay_on   <= rd_q.relay_on;
        out_q.out_relay_off  <= rd_q.relay_off;
        out_q.out_limit_hit  <= rd_q.limit_flag;
        out_q.out_limit_time <= rd_q.limit_time;
      end else begin
        out_q.entry_valid    <= 1'b0;
        out_q.out_time       <= '0;
        out_q.out_kind       <= '0;
        out_q.out_relay_on   <= '0;
        out_q.out_relay_off  <= '0;
        out_q.out_limit_hit  <= 1'b0;
        out_q.out_limit_time <= '0;
      end
    end
  end
endmodule
`default_nettype wire

>>> src/aelb_checker.sv
`default_nettype none
module aelb_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                empty,
  input wire logic                pop,
  input wire aelb_pkg::out_item_t out_item_o
);
  // a result is held until popped
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(out_item_o)) else $error("result dropped");
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> out_item_o.entry_count <= 5'd16) else $error("count out of range");
  a_valid_only_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && out_item_o.entry_valid |-> out_item_o.entry_count != 5'd0)
    else $error("hit on empty log");
  a_zero_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !out_item_o.entry_valid |-> out_item_o.out_time == 32'd0)
    else $error("miss with data");
endmodule

bind aging_event_log_buffer_top aelb_checker u_chk (
  .clk_i, .rst_ni, .empty, .pop, .out_item_o
);
`default_nettype wire
